FILE: src/vbc_pkg.sv
// ----------------------------------------------------------------------------
// vbc_pkg: shared types and constants for the voice band-pass compressor
// Field widths, configuration register indexes and sequencer states.
// ----------------------------------------------------------------------------
package vbc_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 16;
	localparam int CT_W       = 15;
	localparam int QUO_W      = 16;
	localparam int STEP_CNT_W = $clog2(COEF_W);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [COEF_W-1:0] HC_RESET = 16'd49869;
	localparam logic [COEF_W-1:0] LC_RESET = 16'd42820;
	localparam logic [CT_W-1:0]   CT_RESET = 15'd6000;
	localparam logic [COEF_W-1:0] RC_RESET = 16'd66;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE    = 3'd0,
		REG_HP_COEFF  = 3'd1,
		REG_LP_COEFF  = 3'd2,
		REG_THRESHOLD = 3'd3,
		REG_RELEASE   = 3'd4
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HP1,
		ST_HP1_W,
		ST_HP2,
		ST_HP2_W,
		ST_LP1,
		ST_LP1_W,
		ST_LP2,
		ST_LP2_W,
		ST_ENV,
		ST_ENV_W,
		ST_THR,
		ST_DIV_W,
		ST_GAIN_W,
		ST_FIN
	} seq_state_t;

endpackage

FILE: src/vbc_if.sv
// ----------------------------------------------------------------------------
// vbc_if: sample channels
// Valid/ready channels for the audio input and the processed output.
// ----------------------------------------------------------------------------
interface vbc_in_if import vbc_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface vbc_out_if import vbc_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

FILE: src/vbc_mul.sv
// ----------------------------------------------------------------------------
// vbc_mul: bit-serial coefficient multiplier
// floor(coef * opnd / 2^16), one coefficient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module vbc_mul import vbc_pkg::*; #(
	parameter int W = 40
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [COEF_W-1:0]   coef,
	input  logic signed [W-1:0] opnd,
	output logic                done,
	output logic signed [W-1:0] res
);

	localparam int AW = W + COEF_W + 1;

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic [COEF_W-1:0]     coef_q;
	logic signed [W-1:0]   opnd_q;
	logic signed [AW-1:0]  acc_q;
	logic signed [AW-1:0]  addend;

	assign addend = coef_q[cnt_q] ? {{(AW-W){opnd_q[W-1]}}, opnd_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_CNT_W'(COEF_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			coef_q <= coef;
			opnd_q <= opnd;
			acc_q  <= '0;
		end else if (busy_q) begin
			acc_q <= (acc_q <<< 1) + addend;
		end
	end

	// arithmetic shift by 16; magnitude never grows past the operand
	assign res  = acc_q[W+COEF_W-1:COEF_W];
	assign done = done_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("multiplier restarted while busy");

	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("multiplier done without a finished run");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("multiplier done held for more than one cycle");

endmodule

FILE: src/vbc_div.sv
// ----------------------------------------------------------------------------
// vbc_div: restoring fractional divider
// floor(num * 2^16 / den) for num < den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vbc_div import vbc_pkg::*; #(
	parameter int W = 40
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [W-1:0]       num,
	input  logic [W-1:0]       den,
	output logic               done,
	output logic [QUO_W-1:0]   quot
);

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic [W:0]            rem_q;
	logic [W-1:0]          den_q;
	logic [QUO_W-1:0]      quot_q;
	logic [W:0]            trial;
	logic                  ge;

	assign trial = {rem_q[W-1:0], 1'b0};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_CNT_W'(QUO_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
		end else if (busy_q) begin
			rem_q  <= ge ? trial - {1'b0, den_q} : trial;
			quot_q <= {quot_q[QUO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < {1'b0, den_q})
		else $error("divider remainder not below divisor");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held for more than one cycle");

endmodule

FILE: src/voice_bandpass_compressor.sv
// ----------------------------------------------------------------------------
// voice_bandpass_compressor: voice-band filter with peak compressor
// Two one-pole high-pass stages, two one-pole low-pass stages, a peak
// envelope with instant attack and slow release, 8:1 compression above a
// threshold and 2x makeup gain, saturated to 16 bits.
//
//   channel  | dir | payload            | accepted when
//   ---------+-----+--------------------+----------------------------
//   audio    | in  | sample_in  (s16)   | audio.valid & audio.ready
//   result   | out | sample_out (s16)   | result.valid & result.ready
//   cfg      | in  | cfg_index, cfg_data| cfg_we high
//
// Sequencing: one request at a time. Enabled: the time from accept to result
// is set by the 16-step serial multiplier (four to six products, one per
// filter stage) and the 16-step divider. Bypass: straight to the final step.
// Reset: clears all filter and envelope state, loads register defaults.
// Stalls: a result waiting on result.ready does not block the next accept;
// the sequencer holds in its final step until the output register is free.
// ----------------------------------------------------------------------------
module voice_bandpass_compressor import vbc_pkg::*; #(
	parameter int FRAC_BITS   = 16,
	parameter int STATE_WIDTH = 40
) (
	input  logic                  clk,
	input  logic                  arst_n,
	vbc_in_if.sink                audio,
	vbc_out_if.source             result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int W  = STATE_WIDTH;
	localparam int WW = STATE_WIDTH + 20;  // room for sums and the sample shift

	localparam logic signed [WW-1:0] SMAX = {{(WW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [WW-1:0] SMIN = {{(WW-W+1){1'b1}}, {(W-1){1'b0}}};
	localparam logic [W:0]           POS_LIM = (W+1)'(32767);
	localparam logic [W:0]           NEG_LIM = (W+1)'(32768);

	// saturate a wide intermediate to the state range
	function automatic logic signed [W-1:0] sat_w(input logic signed [WW-1:0] v);
		logic signed [W-1:0] r;
		if (v > SMAX)
			r = SMAX[W-1:0];
		else if (v < SMIN)
			r = SMIN[W-1:0];
		else
			r = v[W-1:0];
		return r;
	endfunction

	function automatic logic signed [WW-1:0] ext_w(input logic signed [W-1:0] v);
		return {{(WW-W){v[W-1]}}, v};
	endfunction

	function automatic logic signed [WW-1:0] ext_s(input logic signed [SAMPLE_W-1:0] v);
		return {{(WW-SAMPLE_W){v[SAMPLE_W-1]}}, v};
	endfunction

	// configuration registers
	logic              en_q;
	logic [COEF_W-1:0] hc_q;
	logic [COEF_W-1:0] lc_q;
	logic [CT_W-1:0]   ct_q;
	logic [COEF_W-1:0] rc_q;

	// filter and envelope state
	logic                       last_en_q;
	logic signed [SAMPLE_W-1:0] prev_q;
	logic signed [W-1:0]        hp1_q, hp1p_q, hp2_q, lp1_q, lp2_q, env_q;

	// per-request payload
	logic signed [SAMPLE_W-1:0] smp_q;
	logic                       byp_q;
	logic signed [W-1:0]        y_q;
	logic signed [SAMPLE_W-1:0] out_q;
	logic                       out_valid_q;

	seq_state_t st_q, st_d;

	// shared units
	logic                mul_start, mul_done;
	logic [COEF_W-1:0]   mul_coef;
	logic signed [W-1:0] mul_opnd, mul_res;
	logic                div_start, div_done;
	logic [QUO_W-1:0]    div_quot;

	logic accept, fin_go;

	// datapath terms
	logic signed [W-1:0] x_s, px_s;
	logic signed [W-1:0] hp1_arg, hp2_arg, lp1_arg, lp2_arg;
	logic signed [W-1:0] lp1_new, lp2_new, env_rel;
	logic signed [W-1:0] abs_v, thr_v, diff_v, want_v;
	logic signed [W-1:0] y2_lp, y2_g;
	logic                env_hi, env_ov;
	logic                y_neg;
	logic [W:0]          y_mag, q_mag;
	logic [SAMPLE_W-1:0] q_neg;
	logic signed [SAMPLE_W-1:0] out_val;

	assign accept = audio.valid && audio.ready;
	assign fin_go = !out_valid_q || result.ready;

	assign x_s     = sat_w(ext_s(smp_q) <<< FRAC_BITS);
	assign px_s    = sat_w(ext_s(prev_q) <<< FRAC_BITS);
	assign hp1_arg = sat_w(ext_w(hp1_q) + ext_w(x_s) - ext_w(px_s));
	assign hp2_arg = sat_w(ext_w(hp2_q) + ext_w(hp1_q) - ext_w(hp1p_q));
	assign lp1_arg = sat_w(ext_w(hp2_q) - ext_w(lp1_q));
	assign lp2_arg = sat_w(ext_w(lp1_q) - ext_w(lp2_q));
	assign lp1_new = sat_w(ext_w(lp1_q) + ext_w(mul_res));
	assign lp2_new = sat_w(ext_w(lp2_q) + ext_w(mul_res));
	assign env_rel = sat_w(ext_w(env_q) + ext_w(mul_res));

	// |lp2|, most negative value saturates to the most positive
	assign abs_v  = lp2_q[W-1] ? sat_w(-ext_w(lp2_q)) : lp2_q;
	assign env_hi = abs_v > env_q;

	assign thr_v  = sat_w($signed({{(WW-CT_W){1'b0}}, ct_q}) <<< FRAC_BITS);
	assign env_ov = env_q > thr_v;
	// target level: threshold plus an eighth of the excess; stays below env
	assign diff_v = env_q - thr_v;
	assign want_v = thr_v + (diff_v >>> 3);

	assign y2_lp = sat_w(ext_w(lp2_q) <<< 1);
	assign y2_g  = sat_w(ext_w(mul_res) <<< 1);

	// truncate toward zero by 2^FRAC_BITS, then clamp to 16 bits
	always_comb begin
		y_neg = y_q[W-1];
		y_mag = y_neg ? -{y_q[W-1], y_q} : {y_q[W-1], y_q};
		q_mag = y_mag >> FRAC_BITS;
		q_neg = ~q_mag[SAMPLE_W-1:0] + 1'b1;
		if (!y_neg)
			out_val = (q_mag > POS_LIM) ? 16'sh7fff : q_mag[SAMPLE_W-1:0];
		else
			out_val = (q_mag > NEG_LIM) ? 16'sh8000 : q_neg;
	end

	vbc_mul #(.W(W)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.coef   (mul_coef),
		.opnd   (mul_opnd),
		.done   (mul_done),
		.res    (mul_res)
	);

	vbc_div #(.W(W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (want_v),
		.den    (env_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// sequencer: next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:   if (accept) st_d = en_q ? ST_HP1 : ST_FIN;
			ST_HP1:    st_d = ST_HP1_W;
			ST_HP1_W:  if (mul_done) st_d = ST_HP2;
			ST_HP2:    st_d = ST_HP2_W;
			ST_HP2_W:  if (mul_done) st_d = ST_LP1;
			ST_LP1:    st_d = ST_LP1_W;
			ST_LP1_W:  if (mul_done) st_d = ST_LP2;
			ST_LP2:    st_d = ST_LP2_W;
			ST_LP2_W:  if (mul_done) st_d = ST_ENV;
			ST_ENV:    st_d = env_hi ? ST_THR : ST_ENV_W;
			ST_ENV_W:  if (mul_done) st_d = ST_THR;
			ST_THR:    st_d = env_ov ? ST_DIV_W : ST_FIN;
			ST_DIV_W:  if (div_done) st_d = ST_GAIN_W;
			ST_GAIN_W: if (mul_done) st_d = ST_FIN;
			ST_FIN:    if (fin_go) st_d = ST_IDLE;
			default:   st_d = ST_IDLE;
		endcase
	end

	// sequencer: unit controls
	always_comb begin
		mul_start = 1'b0;
		mul_coef  = '0;
		mul_opnd  = '0;
		div_start = 1'b0;
		unique case (st_q)
			ST_HP1: begin
				mul_start = 1'b1;
				mul_coef  = hc_q;
				mul_opnd  = hp1_arg;
			end
			ST_HP2: begin
				mul_start = 1'b1;
				mul_coef  = hc_q;
				mul_opnd  = hp2_arg;
			end
			ST_LP1: begin
				mul_start = 1'b1;
				mul_coef  = lc_q;
				mul_opnd  = lp1_arg;
			end
			ST_LP2: begin
				mul_start = 1'b1;
				mul_coef  = lc_q;
				mul_opnd  = lp2_arg;
			end
			ST_ENV: begin
				// release only; attack takes the new peak directly
				mul_start = !env_hi;
				mul_coef  = rc_q;
				mul_opnd  = abs_v - env_q;
			end
			ST_THR: begin
				div_start = env_ov;
			end
			ST_DIV_W: begin
				// gain ready: scale lp2 by it right away
				mul_start = div_done;
				mul_coef  = div_quot;
				mul_opnd  = lp2_q;
			end
			default: begin
			end
		endcase
	end

	assign audio.ready       = (st_q == ST_IDLE);
	assign result.valid      = out_valid_q;
	assign result.sample_out = out_q;

	// control and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			en_q        <= 1'b1;
			hc_q        <= HC_RESET;
			lc_q        <= LC_RESET;
			ct_q        <= CT_RESET;
			rc_q        <= RC_RESET;
			last_en_q   <= 1'b1;
			prev_q      <= '0;
			hp1_q       <= '0;
			hp1p_q      <= '0;
			hp2_q       <= '0;
			lp1_q       <= '0;
			lp2_q       <= '0;
			env_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;

			if (cfg_we) begin
				unique case (cfg_index)
					REG_ENABLE:    en_q <= cfg_data[0];
					REG_HP_COEFF:  hc_q <= cfg_data;
					REG_LP_COEFF:  lc_q <= cfg_data;
					REG_THRESHOLD: ct_q <= cfg_data[CT_W-1:0];
					REG_RELEASE:   rc_q <= cfg_data;
					default: begin
					end
				endcase
			end

			// a new result may load in the same cycle the old one leaves
			if (st_q == ST_FIN && fin_go)
				out_valid_q <= 1'b1;
			else if (result.valid && result.ready)
				out_valid_q <= 1'b0;

			case (st_q)
				ST_IDLE: begin
					// enable flip wipes state, bypassed or not
					if (accept && (en_q != last_en_q)) begin
						last_en_q <= en_q;
						prev_q    <= '0;
						hp1_q     <= '0;
						hp1p_q    <= '0;
						hp2_q     <= '0;
						lp1_q     <= '0;
						lp2_q     <= '0;
						env_q     <= '0;
					end
				end
				ST_HP1:   prev_q <= smp_q;
				ST_HP1_W: if (mul_done) hp1_q <= mul_res;
				ST_HP2:   hp1p_q <= hp1_q;
				ST_HP2_W: if (mul_done) hp2_q <= mul_res;
				ST_LP1_W: if (mul_done) lp1_q <= lp1_new;
				ST_LP2_W: if (mul_done) lp2_q <= lp2_new;
				ST_ENV:   if (env_hi) env_q <= abs_v;
				ST_ENV_W: if (mul_done) env_q <= env_rel;
				default: begin
				end
			endcase
		end
	end

	// request payload
	always_ff @(posedge clk) begin
		if (accept) begin
			smp_q <= audio.sample_in;
			byp_q <= !en_q;
		end
		if (st_q == ST_THR && !env_ov)
			y_q <= y2_lp;
		if (st_q == ST_GAIN_W && mul_done)
			y_q <= y2_g;
		if (st_q == ST_FIN && fin_go)
			out_q <= byp_q ? smp_q : out_val;
	end

	a_env_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) |-> !env_q[W-1])
		else $error("envelope went negative");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !audio.ready)
		else $error("second request taken while one is in flight");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |=>
			(result.valid && $stable(result.sample_out)))
		else $error("waiting result dropped or changed");

endmodule
